// File: src/lphm_pkg.sv
// lphm_pkg: shared constants, codes and types of the linear-probe hash map
// no dependencies; used by every module of the block
package lphm_pkg;

    // default sizing handed to the top level parameters
    localparam int LOG2_SLOTS_DEF = 10;
    localparam int VALUE_BITS_DEF = 16;

    // fixed port widths
    localparam int MODE_W = 2;
    localparam int KEY_W  = 64;
    localparam int VALUE_W = 16;
    localparam int SIZE_W = 4;

    // table size register
    localparam logic [SIZE_W-1:0] SIZE_LOG2_RESET = 4'd10;
    localparam logic [SIZE_W:0]   SIZE_LOG2_MIN   = 5'd4;

    // queue between hash front and probe engine
    localparam int QUEUE_DEPTH_LOG2 = 2;

    // splitmix64 finalizer constants
    localparam logic [KEY_W-1:0] MIX_MUL1 = 64'hBF58476D1CE4E5B9;
    localparam logic [KEY_W-1:0] MIX_MUL2 = 64'h94D049BB133111EB;
    localparam int MIX_SHIFT1 = 30;
    localparam int MIX_SHIFT2 = 27;
    localparam int MIX_SHIFT3 = 31;

    // operation codes
    typedef enum logic [MODE_W-1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_CLEAR  = 2'd2
    } lphm_mode_t;

    // probe engine states
    typedef enum logic [1:0] {
        BACK_SWEEP,
        BACK_IDLE,
        BACK_PROBE,
        BACK_EMIT
    } lphm_back_state_t;

    // one result item
    typedef struct packed {
        logic               found;
        logic [VALUE_W-1:0] result_value;
        logic               table_full;
    } lphm_result_t;

endpackage

// File: src/linear_probe_hash_map_unit.sv
// linear_probe_hash_map_unit: top level of the open-addressed hash map
// depends on lphm_pkg, lphm_front, lphm_queue and lphm_back
//
//   channel   direction  handshake            payload
//   s_*       in         s_valid / s_ready    s_mode, s_key, s_value
//   m_*       out        m_valid / m_ready    m_found, m_result_value, m_table_full
//   cfg_*     in         cfg_valid / cfg_ready cfg_data (table_size_log2)
//
// the hash pipeline overlaps the probe engine
// a lookup or insert holds the probe engine until its probe stops, one slot read
// per cycle from the slot memory; a clear holds it while it sweeps every slot
// after reset a sweep empties all 2^LOG2_SLOTS slots; s_ready stays low meanwhile
// a four-entry queue and the result register let either side stall on its own
module linear_probe_hash_map_unit #(
    parameter int LOG2_SLOTS = lphm_pkg::LOG2_SLOTS_DEF,
    parameter int VALUE_BITS = lphm_pkg::VALUE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [lphm_pkg::MODE_W-1:0]   s_mode,
    input  logic [lphm_pkg::KEY_W-1:0]    s_key,
    input  logic [lphm_pkg::VALUE_W-1:0]  s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_found,
    output logic [lphm_pkg::VALUE_W-1:0]  m_result_value,
    output logic                          m_table_full,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lphm_pkg::SIZE_W-1:0]   cfg_data
);

    localparam int LW = LOG2_SLOTS;
    localparam int MW = lphm_pkg::MODE_W;
    localparam int KW = lphm_pkg::KEY_W;
    localparam int QW = MW + KW + VALUE_BITS + LW;

    logic [lphm_pkg::SIZE_W-1:0] table_size_log2_reg;
    logic [lphm_pkg::SIZE_W:0]   size_raw, size_eff;
    logic [LW-1:0]               mask;

    logic                  init_done;
    logic                  fr_valid, fr_ready;
    logic [MW-1:0]         fr_mode;
    logic [KW-1:0]         fr_key;
    logic [VALUE_BITS-1:0] fr_value;
    logic [LW-1:0]         fr_slot;
    logic                  q_valid, q_ready;
    logic [QW-1:0]         q_rd_data;
    lphm_pkg::lphm_result_t res;

    // table size register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_size_log2_reg <= lphm_pkg::SIZE_LOG2_RESET;
        end else if (cfg_valid) begin
            table_size_log2_reg <= cfg_data;
        end
    end

    // clamp the size and build the probe mask
    assign size_raw = {1'b0, table_size_log2_reg};
    always_comb begin
        priority if (size_raw < lphm_pkg::SIZE_LOG2_MIN) begin
            size_eff = lphm_pkg::SIZE_LOG2_MIN;
        end else if (size_raw > (lphm_pkg::SIZE_W + 1)'(LOG2_SLOTS)) begin
            size_eff = (lphm_pkg::SIZE_W + 1)'(LOG2_SLOTS);
        end else begin
            size_eff = size_raw;
        end
    end

    always_comb begin
        for (int i = 0; i < LW; i++) begin
            mask[i] = (lphm_pkg::SIZE_W + 1)'(i) < size_eff;
        end
    end

    // hash front
    lphm_front #(
        .LOG2_SLOTS (LOG2_SLOTS),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_en     (init_done),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_mode   (s_mode),
        .in_key    (s_key),
        .in_value  (s_value),
        .mask      (mask),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_mode  (fr_mode),
        .out_key   (fr_key),
        .out_value (fr_value),
        .out_slot  (fr_slot)
    );

    // queue between front and probe engine
    lphm_queue #(
        .WIDTH (QW)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fr_valid),
        .wr_ready (fr_ready),
        .wr_data  ({fr_mode, fr_key, fr_value, fr_slot}),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_rd_data)
    );

    // probe engine
    lphm_back #(
        .LOG2_SLOTS (LOG2_SLOTS),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .mask      (mask),
        .init_done (init_done),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_mode    (q_rd_data[QW-1 -: MW]),
        .q_key     (q_rd_data[QW-MW-1 -: KW]),
        .q_value   (q_rd_data[LW+VALUE_BITS-1 -: VALUE_BITS]),
        .q_slot    (q_rd_data[LW-1:0]),
        .res_valid (m_valid),
        .res_ready (m_ready),
        .res       (res)
    );

    // result ports
    assign m_found        = res.found;
    assign m_result_value = res.result_value;
    assign m_table_full   = res.table_full;

endmodule

// File: src/lphm_front.sv
// lphm_front: input stage and four-stage splitmix64 hash pipeline
// depends on lphm_pkg; feeds the home slot of each item toward the queue
module lphm_front #(
    parameter int LOG2_SLOTS = lphm_pkg::LOG2_SLOTS_DEF,
    parameter int VALUE_BITS = lphm_pkg::VALUE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_en,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [lphm_pkg::MODE_W-1:0]   in_mode,
    input  logic [lphm_pkg::KEY_W-1:0]    in_key,
    input  logic [lphm_pkg::VALUE_W-1:0]  in_value,
    input  logic [LOG2_SLOTS-1:0]         mask,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lphm_pkg::MODE_W-1:0]   out_mode,
    output logic [lphm_pkg::KEY_W-1:0]    out_key,
    output logic [VALUE_BITS-1:0]         out_value,
    output logic [LOG2_SLOTS-1:0]         out_slot
);

    localparam int KW = lphm_pkg::KEY_W;
    localparam int MW = lphm_pkg::MODE_W;

    logic adv;
    logic st1_valid_reg, st2_valid_reg, st3_valid_reg, st4_valid_reg;
    logic [MW-1:0] st1_mode_reg, st2_mode_reg, st3_mode_reg, st4_mode_reg;
    logic [KW-1:0] st1_key_reg, st2_key_reg, st3_key_reg, st4_key_reg;
    logic [VALUE_BITS-1:0] st1_val_reg, st2_val_reg, st3_val_reg, st4_val_reg;

    logic [KW-1:0] st1_x_reg, st1_x_next;
    logic [63:0]   st2_p0_reg, st2_p0_next;
    logic [31:0]   st2_p1_reg, st2_p1_next, st2_p2_reg, st2_p2_next;
    logic [KW-1:0] st3_x_reg, st3_x_next;
    logic [KW-1:0] st3_sum;
    logic [63:0]   st4_p0_reg, st4_p0_next;
    logic [31:0]   st4_p1_reg, st4_p1_next, st4_p2_reg, st4_p2_next;
    logic [KW-1:0] st4_sum;
    logic [KW-1:0] hash;

    // the whole pipeline moves when its last stage is empty or drained
    assign adv       = !st4_valid_reg || out_ready;
    assign in_ready  = adv && in_en;
    assign out_valid = st4_valid_reg;

    // first xor-shift on the accepted key
    assign st1_x_next = in_key ^ (in_key >> lphm_pkg::MIX_SHIFT1);

    // first multiply, split into 32-bit partial products
    assign st2_p0_next = st1_x_reg[31:0] * lphm_pkg::MIX_MUL1[31:0];
    assign st2_p1_next = st1_x_reg[63:32] * lphm_pkg::MIX_MUL1[31:0];
    assign st2_p2_next = st1_x_reg[31:0] * lphm_pkg::MIX_MUL1[63:32];

    // recombine and second xor-shift
    assign st3_sum    = st2_p0_reg + {st2_p1_reg + st2_p2_reg, 32'b0};
    assign st3_x_next = st3_sum ^ (st3_sum >> lphm_pkg::MIX_SHIFT2);

    // second multiply
    assign st4_p0_next = st3_x_reg[31:0] * lphm_pkg::MIX_MUL2[31:0];
    assign st4_p1_next = st3_x_reg[63:32] * lphm_pkg::MIX_MUL2[31:0];
    assign st4_p2_next = st3_x_reg[31:0] * lphm_pkg::MIX_MUL2[63:32];

    // recombine, last xor-shift and mask to the table in use
    assign st4_sum  = st4_p0_reg + {st4_p1_reg + st4_p2_reg, 32'b0};
    assign hash     = st4_sum ^ (st4_sum >> lphm_pkg::MIX_SHIFT3);
    assign out_slot = hash[LOG2_SLOTS-1:0] & mask;

    assign out_mode  = st4_mode_reg;
    assign out_key   = st4_key_reg;
    assign out_value = st4_val_reg;

    // stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
            st4_valid_reg <= 1'b0;
        end else if (adv) begin
            st1_valid_reg <= in_valid && in_ready;
            st2_valid_reg <= st1_valid_reg;
            st3_valid_reg <= st2_valid_reg;
            st4_valid_reg <= st3_valid_reg;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            st1_mode_reg <= in_mode;
            st1_key_reg  <= in_key;
            st1_val_reg  <= VALUE_BITS'(in_value);
            st1_x_reg    <= st1_x_next;

            st2_mode_reg <= st1_mode_reg;
            st2_key_reg  <= st1_key_reg;
            st2_val_reg  <= st1_val_reg;
            st2_p0_reg   <= st2_p0_next;
            st2_p1_reg   <= st2_p1_next;
            st2_p2_reg   <= st2_p2_next;

            st3_mode_reg <= st2_mode_reg;
            st3_key_reg  <= st2_key_reg;
            st3_val_reg  <= st2_val_reg;
            st3_x_reg    <= st3_x_next;

            st4_mode_reg <= st3_mode_reg;
            st4_key_reg  <= st3_key_reg;
            st4_val_reg  <= st3_val_reg;
            st4_p0_reg   <= st4_p0_next;
            st4_p1_reg   <= st4_p1_next;
            st4_p2_reg   <= st4_p2_next;
        end
    end

endmodule

// File: src/lphm_queue.sv
// lphm_queue: small fifo between the hash front and the probe engine
// depends on lphm_pkg for its depth
module lphm_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    localparam int QAW   = lphm_pkg::QUEUE_DEPTH_LOG2;
    localparam int DEPTH = 1 << QAW;

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [QAW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]     cnt_reg;
    logic             push, pop;

    assign wr_ready = cnt_reg != (QAW + 1)'(DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)      cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push) cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) entry_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// File: src/lphm_back.sv
// lphm_back: probe engine with the slot memory, clearing sweep and result register
// depends on lphm_pkg; takes hashed items from lphm_queue
module lphm_back #(
    parameter int LOG2_SLOTS = lphm_pkg::LOG2_SLOTS_DEF,
    parameter int VALUE_BITS = lphm_pkg::VALUE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [LOG2_SLOTS-1:0]        mask,
    output logic                         init_done,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  logic [lphm_pkg::MODE_W-1:0]  q_mode,
    input  logic [lphm_pkg::KEY_W-1:0]   q_key,
    input  logic [VALUE_BITS-1:0]        q_value,
    input  logic [LOG2_SLOTS-1:0]        q_slot,
    output logic                         res_valid,
    input  logic                         res_ready,
    output lphm_pkg::lphm_result_t       res
);

    localparam int LW    = LOG2_SLOTS;
    localparam int KW    = lphm_pkg::KEY_W;
    localparam int EW    = 1 + KW + VALUE_BITS;
    localparam int DEPTH = 1 << LW;

    lphm_pkg::lphm_back_state_t state_reg, state_next;

    // slot memory: used bit, key, value
    logic [EW-1:0] mem [DEPTH];
    logic [EW-1:0] rd_data_reg;
    logic [LW-1:0] rd_addr, wr_addr;
    logic [EW-1:0] wr_data;
    logic          wr_en;

    logic [lphm_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [KW-1:0]         key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [LW-1:0]         slot_reg, slot_next;
    logic [LW-1:0]         n_reg, n_next;
    logic [LW-1:0]         sweep_cnt_reg, sweep_cnt_next;
    logic                  sweep_emit_reg, sweep_emit_next;
    logic                  init_done_reg, init_done_next;
    lphm_pkg::lphm_result_t res_reg, res_next;
    lphm_pkg::lphm_result_t out_reg;
    logic                  out_valid_reg;
    logic                  out_load, out_free;

    logic                  rd_used;
    logic [KW-1:0]         rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    logic                  probe_empty, probe_hit, probe_last, probe_stop;
    logic [LW-1:0]         slot_inc;
    logic                  sweep_last;

    // fields of the slot read last cycle
    assign rd_used     = rd_data_reg[EW-1];
    assign rd_key      = rd_data_reg[EW-2 -: KW];
    assign rd_val      = rd_data_reg[VALUE_BITS-1:0];
    assign probe_empty = !rd_used;
    assign probe_hit   = rd_used && (rd_key == key_reg);
    assign probe_last  = n_reg == mask;
    assign probe_stop  = probe_empty || probe_hit || probe_last;
    assign slot_inc    = (slot_reg + 1'b1) & mask;
    assign sweep_last  = &sweep_cnt_reg;
    assign out_free    = !out_valid_reg || res_ready;

    assign init_done = init_done_reg;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lphm_pkg::BACK_SWEEP: begin
                if (sweep_last) begin
                    state_next = sweep_emit_reg ? lphm_pkg::BACK_EMIT : lphm_pkg::BACK_IDLE;
                end
            end
            lphm_pkg::BACK_IDLE: begin
                if (q_valid) begin
                    unique case (q_mode)
                        lphm_pkg::MODE_LOOKUP,
                        lphm_pkg::MODE_INSERT: state_next = lphm_pkg::BACK_PROBE;
                        lphm_pkg::MODE_CLEAR:  state_next = lphm_pkg::BACK_SWEEP;
                        default:               state_next = lphm_pkg::BACK_EMIT;
                    endcase
                end
            end
            lphm_pkg::BACK_PROBE: begin
                if (probe_stop) state_next = lphm_pkg::BACK_EMIT;
            end
            lphm_pkg::BACK_EMIT: begin
                if (out_free) state_next = lphm_pkg::BACK_IDLE;
            end
            default: state_next = lphm_pkg::BACK_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        q_ready         = 1'b0;
        rd_addr         = slot_reg;
        wr_en           = 1'b0;
        wr_addr         = slot_reg;
        wr_data         = {1'b1, key_reg, val_reg};
        mode_next       = mode_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        slot_next       = slot_reg;
        n_next          = n_reg;
        sweep_cnt_next  = sweep_cnt_reg;
        sweep_emit_next = sweep_emit_reg;
        init_done_next  = init_done_reg;
        res_next        = res_reg;
        out_load        = 1'b0;
        unique case (state_reg)
            lphm_pkg::BACK_SWEEP: begin
                wr_en          = 1'b1;
                wr_addr        = sweep_cnt_reg;
                wr_data        = '0;
                sweep_cnt_next = sweep_cnt_reg + 1'b1;
                if (sweep_last) init_done_next = 1'b1;
            end
            lphm_pkg::BACK_IDLE: begin
                q_ready         = 1'b1;
                rd_addr         = q_slot;
                mode_next       = q_mode;
                key_next        = q_key;
                val_next        = q_value;
                slot_next       = q_slot;
                n_next          = '0;
                sweep_cnt_next  = '0;
                sweep_emit_next = 1'b1;
                res_next        = '0;
            end
            lphm_pkg::BACK_PROBE: begin
                priority if (probe_empty) begin
                    wr_en = mode_reg == lphm_pkg::MODE_INSERT;
                end else if (probe_hit) begin
                    wr_en          = mode_reg == lphm_pkg::MODE_INSERT;
                    res_next.found = 1'b1;
                    if (mode_reg == lphm_pkg::MODE_LOOKUP) begin
                        res_next.result_value = 16'(rd_val);
                    end
                end else if (probe_last) begin
                    res_next.table_full = 1'b1;
                end else begin
                    slot_next = slot_inc;
                    n_next    = n_reg + 1'b1;
                    rd_addr   = slot_inc;
                end
            end
            lphm_pkg::BACK_EMIT: begin
                out_load = out_free;
            end
            default: begin
                q_ready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= lphm_pkg::BACK_SWEEP;
            sweep_cnt_reg  <= '0;
            sweep_emit_reg <= 1'b0;
            init_done_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            sweep_cnt_reg  <= sweep_cnt_next;
            sweep_emit_reg <= sweep_emit_next;
            init_done_reg  <= init_done_next;
            if (out_load)       out_valid_reg <= 1'b1;
            else if (res_ready) out_valid_reg <= 1'b0;
        end
    end

    // item and result payload
    always_ff @(posedge aclk) begin
        mode_reg <= mode_next;
        key_reg  <= key_next;
        val_reg  <= val_next;
        slot_reg <= slot_next;
        n_reg    <= n_next;
        res_reg  <= res_next;
        if (out_load) out_reg <= res_reg;
    end

    // slot memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

endmodule
